// File: design/rbga_pkg.sv
package rbga_pkg;

   localparam int unsigned WORD_W     = 48;
   localparam int unsigned FRAC_W     = 24;
   localparam int unsigned HALF_W     = 24;
   localparam int unsigned COEFF_N    = 18;
   localparam int unsigned INV_BASE   = 9;
   localparam int unsigned INDEX_W    = 5;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } command_type;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic [WORD_W-1:0] mag;
      logic              neg;
      logic              big;
   } prod_type;

   // magnitude of a 48-bit signed value, 48 bits unsigned (2^47 fits)
   function automatic logic [WORD_W-1:0] mag48(input word_type a);
      logic [WORD_W-1:0] r;
      r = a[WORD_W-1] ? (~a + 1'b1) : a;
      return r;
   endfunction

   // saturate a wide signed sum to 48 bits
   function automatic word_type sat_word(input logic signed [WORD_W+1:0] x,
                                         output logic hit);
      word_type r;
      if (x > $signed({{2{1'b0}}, WORD_MAX})) begin
         r = WORD_MAX; hit = 1'b1;
      end else if (x < $signed({{2{1'b1}}, WORD_MIN})) begin
         r = WORD_MIN; hit = 1'b1;
      end else begin
         r = x[WORD_W-1:0]; hit = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: design/rbga_qmul.sv
// q24.24 multiply, truncating toward zero, saturating; three register stages
module rbga_qmul (
   input  logic                          clock,
   input  logic signed [rbga_pkg::WORD_W-1:0] a,
   input  logic signed [rbga_pkg::WORD_W-1:0] b,
   output logic signed [rbga_pkg::WORD_W-1:0] p,
   output logic                          hit
);
   localparam int unsigned H = rbga_pkg::HALF_W;

   logic [H-1:0]   a1_ff, a0_ff, b1_ff, b0_ff;
   logic           neg_ff, neg2_ff, neg3_ff;
   logic [2*H-1:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic [rbga_pkg::WORD_W+1:0] m_ff;
   logic           big_ff;
   logic [rbga_pkg::WORD_W-1:0] ma, mb;

   assign ma = rbga_pkg::mag48(a);
   assign mb = rbga_pkg::mag48(b);

   always_ff @(posedge clock) begin
      a1_ff  <= ma[2*H-1:H];
      a0_ff  <= ma[H-1:0];
      b1_ff  <= mb[2*H-1:H];
      b0_ff  <= mb[H-1:0];
      neg_ff <= a[rbga_pkg::WORD_W-1] ^ b[rbga_pkg::WORD_W-1];
      hh_ff  <= a1_ff * b1_ff;
      hl_ff  <= a1_ff * b0_ff;
      lh_ff  <= a0_ff * b1_ff;
      ll_ff  <= a0_ff * b0_ff;
      neg2_ff <= neg_ff;
      big_ff <= (hh_ff >= (2*H)'(24'h800000));
      m_ff   <= {hh_ff[H-1:0], {H{1'b0}}} + {2'b00, hl_ff} + {2'b00, lh_ff}
                + {{(H+2){1'b0}}, ll_ff[2*H-1:H]};
      neg3_ff <= neg2_ff;
   end

   always_comb begin
      hit = 1'b0;
      p = -$signed(m_ff[rbga_pkg::WORD_W-1:0]);
      if (!neg3_ff) begin
         if (big_ff || m_ff > {2'b00, rbga_pkg::WORD_MAX}) begin
            hit = 1'b1; p = rbga_pkg::WORD_MAX;
         end else p = m_ff[rbga_pkg::WORD_W-1:0];
      end else if (big_ff || m_ff > {2'b00, 1'b1, {(rbga_pkg::WORD_W-1){1'b0}}}) begin
         hit = 1'b1; p = rbga_pkg::WORD_MIN;
      end
   end
endmodule

// File: design/rigid_body_gyroscopic_accel.sv
// channel | ports                                    | handshake
// req     | req_command .. req_torque_z              | start high, busy low
// rsp     | rsp_accel_x/y/z, rsp_saturated           | rsp_valid strobe, one cycle
// one item enters per cycle; busy is always low
// an evaluate item gives one result on the rsp channel; a load item gives none
// three multiply passes (J*w, w x q, Jinv*g) of three stages each, each with one add stage
// synchronous reset clears valid bits, the saturation flags and the coefficient store
// no stalls: the receiver takes every result
module rigid_body_gyroscopic_accel (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [rbga_pkg::INDEX_W-1:0] req_coeff_index,
   input  logic signed [rbga_pkg::WORD_W-1:0] req_coeff_value,
   input  logic signed [rbga_pkg::WORD_W-1:0] req_rate_x, req_rate_y, req_rate_z,
   input  logic signed [rbga_pkg::WORD_W-1:0] req_momentum_x, req_momentum_y,
   input  logic signed [rbga_pkg::WORD_W-1:0] req_momentum_z,
   input  logic signed [rbga_pkg::WORD_W-1:0] req_torque_x, req_torque_y, req_torque_z,
   output logic        rsp_valid,
   output logic signed [rbga_pkg::WORD_W-1:0] rsp_accel_x, rsp_accel_y, rsp_accel_z,
   output logic        rsp_saturated
);
   localparam int unsigned W   = rbga_pkg::WORD_W;
   localparam int unsigned IXW = rbga_pkg::INDEX_W;
   localparam int unsigned NB  = rbga_pkg::INV_BASE;
   localparam int unsigned BW  = $clog2(NB);
   localparam int unsigned ML  = 3;          // qmul latency
   localparam int unsigned LD  = 2*ML + 2;   // J read to Jinv read
   localparam int unsigned D   = 4*ML + 1;   // total latency

   typedef logic signed [W-1:0] vec_type [3];

   rbga_pkg::word_type j_ff [NB];
   rbga_pkg::word_type k_ff [NB];
   logic [LD-1:0] lv_ff;
   logic [BW-1:0] li_ff [LD];
   rbga_pkg::word_type lx_ff [LD];
   logic take, load_j, load_k;
   logic [BW-1:0] k_idx;
   assign busy = 1'b0;
   assign take = start && !busy;
   assign load_j = take && req_command == rbga_pkg::CMD_LOAD
                   && req_coeff_index < IXW'(NB);
   assign load_k = take && req_command == rbga_pkg::CMD_LOAD
                   && req_coeff_index >= IXW'(NB)
                   && req_coeff_index < IXW'(rbga_pkg::COEFF_N);
   assign k_idx = BW'(req_coeff_index - IXW'(NB));

   // inverse coefficients follow loads after the delay between the two matrix stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) begin
            j_ff[i] <= '0;
            k_ff[i] <= '0;
         end
         lv_ff <= '0;
      end else begin
         if (load_j) j_ff[req_coeff_index[BW-1:0]] <= req_coeff_value;
         if (lv_ff[LD-1]) k_ff[li_ff[LD-1]] <= lx_ff[LD-1];
         lv_ff <= {lv_ff[LD-2:0], load_k};
      end
   end

   always_ff @(posedge clock) begin
      li_ff[0] <= k_idx;
      lx_ff[0] <= req_coeff_value;
      for (int i = 1; i < LD; i++) begin
         li_ff[i] <= li_ff[i-1];
         lx_ff[i] <= lx_ff[i-1];
      end
   end

   // valid and saturation flags per pipeline slot
   logic [D-1:0] v_ff;
   logic [D-1:0] s_ff, s_in;

   // delay lines for w, h, t
   vec_type w_d [ML+2];
   vec_type h_d [ML+1];
   vec_type t_d [2*ML+2];

   always_ff @(posedge clock) begin
      w_d[0] <= '{req_rate_x, req_rate_y, req_rate_z};
      h_d[0] <= '{req_momentum_x, req_momentum_y, req_momentum_z};
      t_d[0] <= '{req_torque_x, req_torque_y, req_torque_z};
      for (int i = 1; i < ML+2; i++) w_d[i] <= w_d[i-1];
      for (int i = 1; i < ML+1; i++) h_d[i] <= h_d[i-1];
      for (int i = 1; i < 2*ML+2; i++) t_d[i] <= t_d[i-1];
   end

   // stage a: J*w products (enter at slot 0 -> out after slot ML)
   vec_type jw_p [3];
   logic [2:0] jw_h [3];
   for (genvar r = 0; r < 3; r++) begin : g_jw
      for (genvar c = 0; c < 3; c++) begin : g_c
         rbga_qmul u_m (.clock(clock), .a(j_ff[3*r+c]), .b(w_d[0][c]),
                        .p(jw_p[r][c]), .hit(jw_h[r][c]));
      end
   end

   // sum and add h (slot ML -> ML+1)
   vec_type q_ff;
   logic q_hit;
   always_comb begin
      logic h1, h2;
      rbga_pkg::word_type s;
      q_hit = |{jw_h[0], jw_h[1], jw_h[2]};
      for (int r = 0; r < 3; r++) begin
         s = rbga_pkg::sat_word(
               (W+2)'(jw_p[r][0]) + (W+2)'(jw_p[r][1]) + (W+2)'(jw_p[r][2]), h1);
         void'(rbga_pkg::sat_word((W+2)'(s) + (W+2)'(h_d[ML][r]), h2));
         q_hit = q_hit | h1 | h2;
      end
   end
   always_ff @(posedge clock) begin
      logic hx;
      rbga_pkg::word_type s;
      for (int r = 0; r < 3; r++) begin
         s = rbga_pkg::sat_word(
               (W+2)'(jw_p[r][0]) + (W+2)'(jw_p[r][1]) + (W+2)'(jw_p[r][2]), hx);
         q_ff[r] <= rbga_pkg::sat_word((W+2)'(s) + (W+2)'(h_d[ML][r]), hx);
      end
   end

   // stage b: cross products w x q (slot ML+1 -> 2ML+1)
   localparam int unsigned SB = ML+1;
   rbga_pkg::word_type cp [6];
   logic [5:0] cp_h;
   rbga_qmul u_c0 (.clock(clock), .a(w_d[SB][1]), .b(q_ff[2]), .p(cp[0]), .hit(cp_h[0]));
   rbga_qmul u_c1 (.clock(clock), .a(w_d[SB][2]), .b(q_ff[1]), .p(cp[1]), .hit(cp_h[1]));
   rbga_qmul u_c2 (.clock(clock), .a(w_d[SB][2]), .b(q_ff[0]), .p(cp[2]), .hit(cp_h[2]));
   rbga_qmul u_c3 (.clock(clock), .a(w_d[SB][0]), .b(q_ff[2]), .p(cp[3]), .hit(cp_h[3]));
   rbga_qmul u_c4 (.clock(clock), .a(w_d[SB][0]), .b(q_ff[1]), .p(cp[4]), .hit(cp_h[4]));
   rbga_qmul u_c5 (.clock(clock), .a(w_d[SB][1]), .b(q_ff[0]), .p(cp[5]), .hit(cp_h[5]));

   // difference, negate, add torque (slot 2ML+1 -> 2ML+2)
   localparam int unsigned SG = 2*ML+1;
   vec_type g_ff;
   logic g_hit;
   always_comb begin
      logic h1, h2, h3;
      rbga_pkg::word_type cc, ng;
      g_hit = |cp_h;
      for (int r = 0; r < 3; r++) begin
         cc = rbga_pkg::sat_word((W+2)'(cp[2*r]) - (W+2)'(cp[2*r+1]), h1);
         ng = rbga_pkg::sat_word(-(W+2)'(cc), h2);
         void'(rbga_pkg::sat_word((W+2)'(t_d[SG][r]) + (W+2)'(ng), h3));
         g_hit = g_hit | h1 | h2 | h3;
      end
   end
   always_ff @(posedge clock) begin
      logic hx;
      rbga_pkg::word_type cc, ng;
      for (int r = 0; r < 3; r++) begin
         cc = rbga_pkg::sat_word((W+2)'(cp[2*r]) - (W+2)'(cp[2*r+1]), hx);
         ng = rbga_pkg::sat_word(-(W+2)'(cc), hx);
         g_ff[r] <= rbga_pkg::sat_word((W+2)'(t_d[SG][r]) + (W+2)'(ng), hx);
      end
   end

   // stage c: Jinv*g (slot 2ML+2 -> 3ML+2)
   vec_type ig_p [3];
   logic [2:0] ig_h [3];
   for (genvar r = 0; r < 3; r++) begin : g_ig
      for (genvar c = 0; c < 3; c++) begin : g_c
         rbga_qmul u_m (.clock(clock), .a(k_ff[3*r+c]),
                        .b(g_ff[c]), .p(ig_p[r][c]), .hit(ig_h[r][c]));
      end
   end

   localparam int unsigned SA = 3*ML+2;
   vec_type a_ff;
   logic a_hit;
   always_comb begin
      logic h1;
      a_hit = |{ig_h[0], ig_h[1], ig_h[2]};
      for (int r = 0; r < 3; r++) begin
         void'(rbga_pkg::sat_word(
            (W+2)'(ig_p[r][0]) + (W+2)'(ig_p[r][1]) + (W+2)'(ig_p[r][2]), h1));
         a_hit = a_hit | h1;
      end
   end
   always_ff @(posedge clock) begin
      logic hx;
      for (int r = 0; r < 3; r++)
         a_ff[r] <= rbga_pkg::sat_word(
            (W+2)'(ig_p[r][0]) + (W+2)'(ig_p[r][1]) + (W+2)'(ig_p[r][2]), hx);
   end

   // flag and valid lines
   always_comb begin
      s_in = {s_ff[D-2:0], 1'b0};
      s_in[ML+1]   = s_ff[ML] | q_hit;
      s_in[2*ML+2] = s_ff[2*ML+1] | g_hit;
      s_in[SA+1]   = s_ff[SA] | a_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         s_ff <= '0;
      end else begin
         v_ff <= {v_ff[D-2:0], take && req_command == rbga_pkg::CMD_EVAL};
         s_ff <= s_in;
      end
   end

   assign rsp_valid     = v_ff[SA+1];
   assign rsp_accel_x   = a_ff[0];
   assign rsp_accel_y   = a_ff[1];
   assign rsp_accel_z   = a_ff[2];
   assign rsp_saturated = s_ff[SA+1];
endmodule
